// File: hdl/ngs_pkg.sv
// Shared types, constants and helpers for the n-body gravity step block.
// Used by nbody_gravity_step, ngs_div and ngs_checker; depends on nothing.
`default_nettype none
package ngs_pkg;

    // Default store depth and fixed field widths
    localparam int MAX_BODIES_DEF = 16;
    localparam int PADDR_W        = 5;
    localparam int S_TDATA_W      = 264;
    localparam int M_TDATA_W      = 200;

    // Register reset values
    localparam logic [6:0]  BODY_COUNT_RST = 7'd0;
    localparam logic [31:0] GRAV_CONST_RST = 32'h0001_0000;
    localparam logic [31:0] TIME_SCALE_RST = 32'h0001_0000;
    localparam logic [31:0] MAX_DELTA_RST  = 32'h0001_0000;
    localparam logic        PAUSED_RST     = 1'b1;

    // Register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_BODY_COUNT = 3'd0;
    localparam logic [2:0] REG_GRAV_CONST = 3'd1;
    localparam logic [2:0] REG_TIME_SCALE = 3'd2;
    localparam logic [2:0] REG_MAX_DELTA  = 3'd3;
    localparam logic [2:0] REG_PAUSED     = 3'd4;

    // Operation codes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // One body in the store
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      mass;
        logic             dyn;
    } t_body;

    // Status returned by the serial divider
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [32:0] rem;
    } t_div_resp;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE, ST_DT_MUL, ST_DT,
        ST_PR_RDI, ST_PR_RDJ, ST_PR_LAT, ST_DIFF, ST_SQ_MUL, ST_SQ_ACC,
        ST_SQRT, ST_DIST, ST_U_DIV, ST_U_WAIT,
        ST_G_MUL, ST_Q_DIV, ST_Q_WAIT, ST_T_DIV, ST_T_WAIT, ST_F_DIV, ST_F_WAIT,
        ST_A_MUL, ST_DV, ST_C_MUL_A, ST_C_MUL_B, ST_C_ADD,
        ST_WR_I, ST_WR_J, ST_NEXT,
        ST_AD_RD, ST_AD_LAT, ST_AD_MUL, ST_AD_ADD, ST_AD_WR, ST_OUT
    } t_state;

    // Saturate a wide signed value to signed 32 bit.
    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        logic [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/nbody_gravity_step.sv
// Load: ready again the next cycle. Step: each body pair takes up to nine serial divisions
// and an iterative square root; result beats wait on m_tready; one result per body.
// Not ready while a step runs. Synchronous active-low reset clears the sequencer and
// the registers to their reset values; the body store is not cleared.
// Depends on ngs_pkg and ngs_div.
`default_nettype none
module nbody_gravity_step import ngs_pkg::*; #(
    parameter int MAX_BODIES = MAX_BODIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input beats
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata from bit 0: body_index(6) pos_x pos_y pos_z vel_x vel_y vel_z mass(32 each)
    //                   is_dynamic(1) delta_time(32) zero(1)
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // tuser: operation(1)
    input  wire logic                 s_tuser,
    // Result beats
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tdata from bit 0: out_index(6) new_pos_x/y/z new_vel_x/y/z (32 each) zero(2)
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast,
    // Configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

    // Configuration registers
    logic [6:0]  r_body_count;
    logic [31:0] r_grav;
    logic [31:0] r_tscale;
    logic [31:0] r_maxd;
    logic        r_paused;

    // Store and working registers
    t_body r_mem [MAX_BODIES];
    t_body r_rd;
    t_body r_a;
    t_body r_b;

    t_state r_state, n_state;
    logic [6:0]        r_n, r_i, r_j;
    logic [1:0]        r_ax;
    logic              r_side;
    logic              r_k;
    logic [2:0][32:0]  r_d;
    logic [2:0][32:0]  r_mag;
    logic [63:0]       r_sum, r_res, r_bit;
    logic [32:0]       r_dist;
    logic [2:0][30:0]  r_u;
    logic [63:0]       r_t;
    logic [15:0]       r_h;
    logic [32:0]       r_r2;
    logic [31:0]       r_acc;
    logic [1:0][31:0]  r_dv;
    logic [31:0]       r_ca;
    logic [31:0]       r_dt;
    logic [63:0]       r_prod;

    logic [31:0] mul_a, mul_b;
    logic        div_start;
    logic [63:0] div_num;
    t_div_resp   div_rsp;

    logic            in_acc, cfg_wr;
    logic [2:0]      cfg_idx;
    logic [5:0]      in_index;
    t_body           in_body;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    t_body           mem_wdata;

    logic [2:0][32:0] dif, dmag;
    logic [63:0]      trial;
    logic [32:0]      dist_c;
    logic [31:0]      vel_c, vmag_c;
    logic signed [49:0] add_a, add_b, dpos;

    // Handshakes and input fields
    assign s_tready = (r_state == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign in_index = s_tdata[5:0];
    assign in_body.pos  = s_tdata[101:6];
    assign in_body.vel  = s_tdata[197:102];
    assign in_body.mass = s_tdata[229:198];
    assign in_body.dyn  = s_tdata[230];

    // APB register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        case (cfg_idx)
            REG_BODY_COUNT: prdata = {25'd0, r_body_count};
            REG_GRAV_CONST: prdata = r_grav;
            REG_TIME_SCALE: prdata = r_tscale;
            REG_MAX_DELTA:  prdata = r_maxd;
            REG_PAUSED:     prdata = {31'd0, r_paused};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_count <= BODY_COUNT_RST;
            r_grav       <= GRAV_CONST_RST;
            r_tscale     <= TIME_SCALE_RST;
            r_maxd       <= MAX_DELTA_RST;
            r_paused     <= PAUSED_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BODY_COUNT: r_body_count <= pwdata[6:0];
                REG_GRAV_CONST: r_grav       <= pwdata;
                REG_TIME_SCALE: r_tscale     <= pwdata;
                REG_MAX_DELTA:  r_maxd       <= pwdata;
                REG_PAUSED:     r_paused     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Shared serial divider
    ngs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_dist),
        .o_rsp   (div_rsp)
    );

    // Shared multiplier with registered product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Body store: one write port, one registered read port
    assign mem_raddr = (r_state == ST_PR_RDJ) ? r_j[AW-1:0] : r_i[AW-1:0];
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // Combinational helpers for the pair math
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dif[c]  = 33'({r_b.pos[c][31], r_b.pos[c]} - {r_a.pos[c][31], r_a.pos[c]});
            dmag[c] = dif[c][32] ? 33'(-dif[c]) : dif[c];
        end
        trial  = r_res + r_bit;
        dist_c = r_k ? {r_res[31:0], 1'b0} : {1'b0, r_res[31:0]};
        vel_c  = r_a.vel[r_ax];
        vmag_c = vel_c[31] ? 32'(-vel_c) : vel_c;
        add_a  = r_d[r_ax][32] ? -50'(r_ca) : 50'(r_ca);
        add_b  = r_d[r_ax][32] ? -50'(r_prod[61:30]) : 50'(r_prod[61:30]);
        dpos   = vel_c[31] ? -50'((r_prod + 64'h0000_FFFF) >> 16) : 50'(r_prod >> 16);
    end

    // Sequencer: next state, multiplier operands, divider and store control
    always_comb begin
        n_state   = r_state;
        mul_a     = 32'd0;
        mul_b     = 32'd0;
        div_start = 1'b0;
        div_num   = r_prod;
        mem_we    = 1'b0;
        mem_waddr = r_i[AW-1:0];
        mem_wdata = r_a;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == OP_STEP) begin
                        n_state = ST_DT_MUL;
                    end else if ({1'b0, in_index} < 7'(MAX_BODIES)) begin
                        mem_we    = 1'b1;
                        mem_waddr = in_index[AW-1:0];
                        mem_wdata = in_body;
                    end
                end
            end
            ST_DT_MUL: begin
                mul_a   = r_dt;
                mul_b   = r_tscale;
                n_state = ST_DT;
            end
            ST_DT: begin
                if (r_n >= 7'd2)      n_state = ST_PR_RDI;
                else if (r_n != 7'd0) n_state = ST_AD_RD;
                else                  n_state = ST_IDLE;
            end
            ST_PR_RDI: n_state = ST_PR_RDJ;
            ST_PR_RDJ: n_state = ST_PR_LAT;
            ST_PR_LAT: n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_SQ_MUL;
            ST_SQ_MUL: begin
                mul_a   = r_k ? r_mag[r_ax][32:1] : r_mag[r_ax][31:0];
                mul_b   = mul_a;
                n_state = ST_SQ_ACC;
            end
            ST_SQ_ACC: n_state = (r_ax == 2'd2) ? ST_SQRT : ST_SQ_MUL;
            ST_SQRT:   if (r_bit[0]) n_state = ST_DIST;
            ST_DIST:   n_state = (dist_c == 33'd0) ? ST_NEXT : ST_U_DIV;
            ST_U_DIV: begin
                div_start = 1'b1;
                div_num   = {1'b0, r_mag[r_ax], 30'd0};
                n_state   = ST_U_WAIT;
            end
            ST_U_WAIT: if (div_rsp.done) n_state = (r_ax == 2'd2) ? ST_G_MUL : ST_U_DIV;
            ST_G_MUL: begin
                mul_a   = r_grav;
                mul_b   = r_side ? r_a.mass : r_b.mass;
                n_state = ST_Q_DIV;
            end
            ST_Q_DIV: begin
                div_start = 1'b1;
                n_state   = ST_Q_WAIT;
            end
            ST_Q_WAIT: if (div_rsp.done) n_state = ST_T_DIV;
            ST_T_DIV: begin
                div_start = 1'b1;
                div_num   = r_t;
                n_state   = ST_T_WAIT;
            end
            ST_T_WAIT: begin
                if (div_rsp.done) n_state = (|div_rsp.quot[63:16]) ? ST_A_MUL : ST_F_DIV;
            end
            ST_F_DIV: begin
                div_start = 1'b1;
                div_num   = {15'd0, r_r2, 16'd0};
                n_state   = ST_F_WAIT;
            end
            ST_F_WAIT: if (div_rsp.done) n_state = ST_A_MUL;
            ST_A_MUL: begin
                mul_a   = r_acc;
                mul_b   = r_dt;
                n_state = ST_DV;
            end
            ST_DV: n_state = r_side ? ST_C_MUL_A : ST_G_MUL;
            ST_C_MUL_A: begin
                mul_a   = r_dv[0];
                mul_b   = {1'b0, r_u[r_ax]};
                n_state = ST_C_MUL_B;
            end
            ST_C_MUL_B: begin
                mul_a   = r_dv[1];
                mul_b   = {1'b0, r_u[r_ax]};
                n_state = ST_C_ADD;
            end
            ST_C_ADD: n_state = (r_ax == 2'd2) ? ST_WR_I : ST_C_MUL_A;
            ST_WR_I: begin
                mem_we  = 1'b1;
                n_state = ST_WR_J;
            end
            ST_WR_J: begin
                mem_we    = 1'b1;
                mem_waddr = r_j[AW-1:0];
                mem_wdata = r_b;
                n_state   = ST_NEXT;
            end
            ST_NEXT: begin
                if ((r_j + 7'd1 < r_n) || (r_i + 7'd2 < r_n)) n_state = ST_PR_RDI;
                else                                          n_state = ST_AD_RD;
            end
            ST_AD_RD:  n_state = ST_AD_LAT;
            ST_AD_LAT: n_state = r_rd.dyn ? ST_AD_MUL : ST_OUT;
            ST_AD_MUL: begin
                mul_a   = vmag_c;
                mul_b   = r_dt;
                n_state = ST_AD_ADD;
            end
            ST_AD_ADD: n_state = (r_ax == 2'd2) ? ST_AD_WR : ST_AD_MUL;
            ST_AD_WR: begin
                mem_we  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) n_state = m_tlast ? ST_IDLE : ST_AD_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= 7'd0;
            r_j     <= 7'd0;
            r_ax    <= 2'd0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_DT: begin
                    r_i <= 7'd0;
                    r_j <= 7'd1;
                end
                ST_DIFF, ST_DIST: r_ax <= 2'd0;
                ST_SQ_ACC, ST_AD_ADD: r_ax <= r_ax + 2'd1;
                ST_U_WAIT: begin
                    if (div_rsp.done) begin
                        r_ax   <= r_ax + 2'd1;
                        r_side <= 1'b0;
                    end
                end
                ST_DV: begin
                    r_side <= 1'b1;
                    r_ax   <= 2'd0;
                end
                ST_C_ADD: r_ax <= r_ax + 2'd1;
                ST_NEXT: begin
                    if (r_j + 7'd1 < r_n) begin
                        r_j <= r_j + 7'd1;
                    end else if (r_i + 7'd2 < r_n) begin
                        r_i <= r_i + 7'd1;
                        r_j <= r_i + 7'd2;
                    end else begin
                        r_i <= 7'd0;
                    end
                end
                ST_AD_LAT: r_ax <= 2'd0;
                ST_OUT: if (m_tready) r_i <= r_i + 7'd1;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dt <= s_tdata[262:231];
                r_n  <= (r_body_count > 7'(MAX_BODIES)) ? 7'(MAX_BODIES) : r_body_count;
            end
            ST_DT: begin
                if (r_paused)                        r_dt <= 32'd0;
                else if (r_prod[63:16] > 48'(r_maxd)) r_dt <= r_maxd;
                else                                 r_dt <= r_prod[47:16];
            end
            ST_PR_RDJ: r_a <= r_rd;
            ST_PR_LAT: r_b <= r_rd;
            ST_DIFF: begin
                r_d   <= dif;
                r_mag <= dmag;
                r_k   <= dmag[0][32] | dmag[0][31] | dmag[1][32] | dmag[1][31]
                       | dmag[2][32] | dmag[2][31];
                r_sum <= 64'd0;
            end
            ST_SQ_ACC: begin
                r_sum <= r_sum + r_prod;
                r_res <= 64'd0;
                r_bit <= 64'd1 << 62;
            end
            ST_SQRT: begin
                if (r_sum >= trial) begin
                    r_sum <= r_sum - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DIST: r_dist <= dist_c;
            ST_U_WAIT: begin
                if (div_rsp.done) begin
                    r_u[r_ax] <= (div_rsp.quot > 64'd1 << 30) ? 31'h4000_0000
                                                               : div_rsp.quot[30:0];
                end
            end
            ST_Q_WAIT: if (div_rsp.done) r_t <= div_rsp.quot;
            ST_T_WAIT: begin
                r_acc <= 32'hFFFF_FFFF;
                r_h   <= div_rsp.quot[15:0];
                r_r2  <= div_rsp.rem;
            end
            ST_F_WAIT: r_acc <= {r_h, div_rsp.quot[15:0]};
            ST_DV: r_dv[r_side] <= (|r_prod[63:48]) ? 32'hFFFF_FFFF : r_prod[47:16];
            ST_C_MUL_B: r_ca <= r_prod[61:30];
            ST_C_ADD: begin
                r_a.vel[r_ax] <= sat32(50'($signed(r_a.vel[r_ax])) + add_a);
                r_b.vel[r_ax] <= sat32(50'($signed(r_b.vel[r_ax])) - add_b);
            end
            ST_AD_LAT: r_a <= r_rd;
            ST_AD_ADD: r_a.pos[r_ax] <= sat32(50'($signed(r_a.pos[r_ax])) + dpos);
            default: ;
        endcase
    end

    // Result beat straight from the working registers
    assign m_tvalid = (r_state == ST_OUT);
    assign m_tlast  = (r_i + 7'd1 == r_n);
    assign m_tdata  = {2'b00, r_a.vel[2], r_a.vel[1], r_a.vel[0],
                       r_a.pos[2], r_a.pos[1], r_a.pos[0], r_i[5:0]};

endmodule
`default_nettype wire

// File: hdl/ngs_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 33-bit divisor.
// Depends on ngs_pkg for the response struct.
`default_nettype none
module ngs_div import ngs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [32:0] i_den,
    output t_div_resp        o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [32:0] r_den;

    logic [33:0] rem_sh;
    logic        fits;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        rem_sh = {r_rem, r_quo[63]};
        fits   = (rem_sh >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 33'd0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];
            r_quo <= {r_quo[62:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

// File: hdl/ngs_checker.sv
// Port-level assertions for nbody_gravity_step, attached by the bind below.
// Depends on ngs_pkg for widths and operation codes.
`default_nettype none
module ngs_checker import ngs_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 pready
);

    // Input is never taken while a result beat is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid)) else $error("input ready during result beat");

    // Reset leaves the block idle and ready.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_tready && !m_tvalid)) else $error("not idle after reset");

    // After a load beat the block is ready again in the next cycle.
    a_load_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_LOAD)) |=> s_tready)
        else $error("load did not return to ready");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // The register port never waits.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind nbody_gravity_step ngs_checker u_ngs_checker (.*);
`default_nettype wire
